### sv/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// Max-heap priority queue package
// Sizes, codes, types and the command and status words shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package mhpq_pkg;

   localparam int HEAP_DEPTH = 1024;
   localparam int ADDR_W     = $clog2(HEAP_DEPTH);
   localparam int COUNT_W    = $clog2(HEAP_DEPTH + 1);
   localparam int KEY_W      = 32;
   localparam int TOTAL_W    = 11;
   localparam int ACTION_W   = 2;
   localparam int STATUS_W   = 2;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [ADDR_W-1:0]       addr_type;
   typedef logic [COUNT_W-1:0]      count_type;
   typedef logic [TOTAL_W-1:0]      total_type;
   typedef logic [ACTION_W-1:0]     action_type;
   typedef logic [STATUS_W-1:0]     status_type;

   localparam action_type ACT_INSERT = 2'd0;
   localparam action_type ACT_REMOVE = 2'd1;
   localparam action_type ACT_PEEK   = 2'd2;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_FULL  = 2'd1;
   localparam status_type STATUS_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      RD_PARENT,
      RD_LAST,
      RD_LEFT,
      RD_RIGHT
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_KEY,
      WR_UP,
      WR_DOWN
   } wr_sel_type;

   typedef struct packed {
      logic       ins_start;
      logic       rem_start;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       pos_root;
      logic       cap_key;
      logic       cap_left;
      wr_sel_type wr_sel;
      logic       rsp_load;
      status_type status_code;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic pos_root;
      logic left_ok;
      logic up_move;
      logic down_move;
   } dp_stat_type;

endpackage

### sv/mhpq_if.sv
// ----------------------------------------------------------------------------
// Max-heap priority queue channels
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface mhpq_req_if;
   import mhpq_pkg::*;

   logic       valid;
   logic       ready;
   action_type action;
   key_type    key_value;

   modport source (output valid, output action, output key_value, input ready);
   modport sink   (input valid, input action, input key_value, output ready);
endinterface

interface mhpq_rsp_if;
   import mhpq_pkg::*;

   logic       valid;
   logic       ready;
   key_type    top_key;
   total_type  entry_total;
   logic       is_empty;
   status_type status;

   modport source (output valid, output top_key, output entry_total, output is_empty,
                   output status, input ready);
   modport sink   (input valid, input top_key, input entry_total, input is_empty,
                   input status, output ready);
endinterface

### sv/max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// Max-heap priority queue
// A peek or a refused word goes straight to the response; an insert climbs
// its key one level at a time and a remove sinks the last key one level at a
// time, at most log2(HEAP_DEPTH) levels.
// One word is in work at a time; the next is taken while a response waits.
// Reset empties the heap by clearing the entry count; memory is not swept.
// ----------------------------------------------------------------------------
module max_heap_priority_queue (
   input logic        clock,
   input logic        reset,
   mhpq_req_if.sink   req_ch,
   mhpq_rsp_if.source rsp_ch
);
   import mhpq_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   mhpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_action (req_ch.action),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mhpq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_key         (req_ch.key_value),
      .rsp_top_key     (rsp_ch.top_key),
      .rsp_entry_total (rsp_ch.entry_total),
      .rsp_is_empty    (rsp_ch.is_empty),
      .rsp_status      (rsp_ch.status)
   );

`ifndef NO_ASSERTIONS
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request accepted twice in a row");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_sel != WR_NONE) |-> !req_ch.ready)
      else $error("heap memory written while idle");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.is_empty) |-> (rsp_ch.top_key == '0))
      else $error("empty heap reports a nonzero top key");

   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_ch.valid)
      else $error("response load did not raise valid");
`endif

endmodule

### sv/mhpq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### sv/mhpq_ctrl.sv
// ----------------------------------------------------------------------------
// Max-heap priority queue controller
// Sequences the sift-up and sift-down walks and the response handshake.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mhpq_pkg::action_type  req_action,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  mhpq_pkg::dp_stat_type stat,
   output mhpq_pkg::dp_cmd_type  cmd
);
   import mhpq_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_RD,
      S_UP_CMP,
      S_DN_LAST,
      S_DN_KEY,
      S_DN_LEFT,
      S_DN_RIGHT,
      S_DN_CMP,
      S_RESP
   } state_type;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in        = state_ff;
      status_in       = status_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      cmd             = '0;
      cmd.rd_sel      = RD_PARENT;
      cmd.wr_sel      = WR_NONE;
      cmd.status_code = status_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               status_in = STATUS_OK;
               state_in  = S_RESP;
               if (req_action == ACT_INSERT) begin
                  if (stat.full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     cmd.ins_start = 1'b1;
                     state_in      = S_UP_RD;
                  end
               end else if (req_action == ACT_REMOVE) begin
                  if (stat.empty) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     cmd.rem_start = 1'b1;
                     state_in      = S_DN_LAST;
                  end
               end
            end
         end
         S_UP_RD: begin
            if (stat.pos_root) begin
               cmd.wr_sel = WR_KEY;
               state_in   = S_RESP;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PARENT;
               state_in   = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (stat.up_move) begin
               cmd.wr_sel = WR_UP;
               state_in   = S_UP_RD;
            end else begin
               cmd.wr_sel = WR_KEY;
               state_in   = S_RESP;
            end
         end
         S_DN_LAST: begin
            if (stat.empty) begin
               state_in = S_RESP;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.rd_sel   = RD_LAST;
               cmd.pos_root = 1'b1;
               state_in     = S_DN_KEY;
            end
         end
         S_DN_KEY: begin
            cmd.cap_key = 1'b1;
            state_in    = S_DN_LEFT;
         end
         S_DN_LEFT: begin
            if (stat.left_ok) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LEFT;
               state_in   = S_DN_RIGHT;
            end else begin
               cmd.wr_sel = WR_KEY;
               state_in   = S_RESP;
            end
         end
         S_DN_RIGHT: begin
            cmd.cap_left = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = RD_RIGHT;
            state_in     = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (stat.down_move) begin
               cmd.wr_sel = WR_DOWN;
               state_in   = S_DN_LEFT;
            end else begin
               cmd.wr_sel = WR_KEY;
               state_in   = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### sv/mhpq_datapath.sv
// ----------------------------------------------------------------------------
// Max-heap priority queue datapath
// Heap memory, entry count, walk position, moving key, root copy and the
// response word register.
// ----------------------------------------------------------------------------
module mhpq_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  mhpq_pkg::dp_cmd_type  cmd,
   output mhpq_pkg::dp_stat_type stat,
   input  mhpq_pkg::key_type     req_key,
   output mhpq_pkg::key_type     rsp_top_key,
   output mhpq_pkg::total_type   rsp_entry_total,
   output logic                  rsp_is_empty,
   output mhpq_pkg::status_type  rsp_status
);
   import mhpq_pkg::*;

   localparam int CMP_W = ADDR_W + 2;

   count_type  count_ff, count_in;
   addr_type   pos_ff, pos_in;
   key_type    key_ff;
   key_type    left_ff;
   key_type    top_ff;
   key_type    top_out_ff;
   total_type  total_out_ff;
   logic       empty_out_ff;
   status_type status_out_ff;

   key_type            rd_data;
   addr_type           rd_addr;
   logic               wr_en;
   key_type            wr_data;
   addr_type           parent_idx;
   logic [CMP_W-1:0]   left_wide;
   logic [CMP_W-1:0]   right_wide;
   logic [CMP_W-1:0]   count_wide;
   addr_type           left_addr;
   addr_type           right_addr;
   logic               choose_right;
   key_type            child_val;
   addr_type           child_idx;

   assign parent_idx   = (pos_ff - addr_type'(1)) >> 1;
   assign left_wide    = CMP_W'({pos_ff, 1'b1});
   assign right_wide   = left_wide + CMP_W'(1);
   assign count_wide   = CMP_W'(count_ff);
   assign left_addr    = left_wide[ADDR_W-1:0];
   assign right_addr   = right_wide[ADDR_W-1:0];
   assign choose_right = (right_wide < count_wide) && (rd_data > left_ff);
   assign child_val    = choose_right ? rd_data : left_ff;
   assign child_idx    = choose_right ? right_addr : left_addr;

   assign stat.full      = (count_ff >= count_type'(HEAP_DEPTH));
   assign stat.empty     = (count_ff == '0);
   assign stat.pos_root  = (pos_ff == '0);
   assign stat.left_ok   = (left_wide < count_wide);
   assign stat.up_move   = (key_ff > rd_data);
   assign stat.down_move = (child_val > key_ff);

   always_comb begin
      case (cmd.rd_sel)
         RD_PARENT: rd_addr = parent_idx;
         RD_LAST:   rd_addr = count_ff[ADDR_W-1:0];
         RD_LEFT:   rd_addr = left_addr;
         RD_RIGHT:  rd_addr = right_addr;
         default:   rd_addr = parent_idx;
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_data = key_ff;
      pos_in  = pos_ff;
      case (cmd.wr_sel)
         WR_KEY: begin
            wr_data = key_ff;
         end
         WR_UP: begin
            wr_data = rd_data;
            pos_in  = parent_idx;
         end
         WR_DOWN: begin
            wr_data = child_val;
            pos_in  = child_idx;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
      if (cmd.ins_start) begin
         pos_in = count_ff[ADDR_W-1:0];
      end else if (cmd.pos_root) begin
         pos_in = '0;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.ins_start) begin
         count_in = count_ff + count_type'(1);
      end else if (cmd.rem_start) begin
         count_in = count_ff - count_type'(1);
      end
   end

   mhpq_ram #(
      .WIDTH (KEY_W),
      .DEPTH (HEAP_DEPTH)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (cmd.ins_start) begin
         key_ff <= req_key;
      end else if (cmd.cap_key) begin
         key_ff <= rd_data;
      end
      if (cmd.cap_left) begin
         left_ff <= rd_data;
      end
      if (wr_en && (pos_ff == '0)) begin
         top_ff <= wr_data;
      end
      if (cmd.rsp_load) begin
         top_out_ff    <= stat.empty ? key_type'(0) : top_ff;
         total_out_ff  <= total_type'(count_ff);
         empty_out_ff  <= stat.empty;
         status_out_ff <= cmd.status_code;
      end
   end

   assign rsp_top_key     = top_out_ff;
   assign rsp_entry_total = total_out_ff;
   assign rsp_is_empty    = empty_out_ff;
   assign rsp_status      = status_out_ff;

endmodule
